[sv/wssm_pkg.sv]
package wssm_pkg;

	typedef struct packed {
		logic        opcode;
		logic [9:0]  row_index;
		logic [31:0] case_cum;
		logic [31:0] total_cum;
		logic [31:0] case_point;
		logic [31:0] total_point;
		logic [31:0] grid_position;
	} item_t;

	typedef struct packed {
		logic [9:0]         start_row;
		logic [31:0]        window_start;
		logic [31:0]        window_end;
		logic signed [31:0] best_statistic;
	} result_t;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_SCAN = 1'b1;

	localparam logic [2:0] REG_CASE_FRACTION = 3'd0;
	localparam logic [2:0] REG_SCALE_FACTOR  = 3'd1;
	localparam logic [2:0] REG_TOTAL_COUNT   = 3'd2;
	localparam logic [2:0] REG_MAX_WINDOW    = 3'd3;
	localparam logic [2:0] REG_SCAN_MODE     = 3'd4;
	localparam logic [2:0] REG_LEFT_CENTER   = 3'd5;
	localparam logic [2:0] REG_RIGHT_CENTER  = 3'd6;

	typedef struct packed {
		logic load_wr;
		logic scan_start;
		logic rd_i;
		logic cap_i;
		logic rd_j;
		logic cap_obs;
		logic eval;
		logic div1_start;
		logic div2_start;
		logic div_step;
		logic v_from_obs;
		logic v_from_div;
		logic mul1;
		logic mul2;
		logic sq_start;
		logic sq_step;
		logic res_zero;
		logic res_sat;
		logic res_div;
		logic upd;
		logic rd_best;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic range_ok;
		logic j_over;
		logic rabin;
		logic early_zero;
		logic div_done;
		logic v_neg;
		logic sq_done;
		logic sat;
	} sts_t;

endpackage

[sv/wssm_ctrl.sv]
module wssm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  logic            item_is_scan,
	output logic            result_valid,
	input  logic            result_ready,
	output wssm_pkg::cmd_t  cmd,
	input  wssm_pkg::sts_t  sts
);
	import wssm_pkg::*;

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_RANGE = 5'd1;
	localparam logic [4:0] S_CAPI  = 5'd2;
	localparam logic [4:0] S_JCHK  = 5'd3;
	localparam logic [4:0] S_JWAIT = 5'd4;
	localparam logic [4:0] S_EVAL  = 5'd5;
	localparam logic [4:0] S_CHK   = 5'd6;
	localparam logic [4:0] S_DIV1  = 5'd7;
	localparam logic [4:0] S_VFIN  = 5'd8;
	localparam logic [4:0] S_MUL1  = 5'd9;
	localparam logic [4:0] S_MUL2  = 5'd10;
	localparam logic [4:0] S_SQS   = 5'd11;
	localparam logic [4:0] S_SQRT  = 5'd12;
	localparam logic [4:0] S_SATC  = 5'd13;
	localparam logic [4:0] S_DIV2  = 5'd14;
	localparam logic [4:0] S_UPD   = 5'd15;
	localparam logic [4:0] S_FIN   = 5'd16;

	logic [4:0] state_q, state_d;
	logic       result_valid_q;

	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = result_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					if (item_is_scan) begin
						cmd.scan_start = 1'b1;
						state_d        = S_RANGE;
					end else begin
						cmd.load_wr = 1'b1;
					end
				end
			end
			S_RANGE: begin
				if (sts.range_ok) begin
					cmd.rd_i = 1'b1;
					state_d  = S_CAPI;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_CAPI: begin
				cmd.cap_i = 1'b1;
				state_d   = S_JCHK;
			end
			S_JCHK: begin
				if (sts.j_over) begin
					cmd.rd_best = 1'b1;
					state_d     = S_FIN;
				end else begin
					cmd.rd_j = 1'b1;
					state_d  = S_JWAIT;
				end
			end
			S_JWAIT: begin
				cmd.cap_obs = 1'b1;
				state_d     = S_EVAL;
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = S_CHK;
			end
			S_CHK: begin
				if (sts.early_zero) begin
					cmd.res_zero = 1'b1;
					state_d      = S_UPD;
				end else if (sts.rabin) begin
					cmd.div1_start = 1'b1;
					state_d        = S_DIV1;
				end else begin
					cmd.v_from_obs = 1'b1;
					state_d        = S_MUL1;
				end
			end
			S_DIV1: begin
				if (sts.div_done) begin
					state_d = S_VFIN;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_VFIN: begin
				if (sts.v_neg) begin
					cmd.res_zero = 1'b1;
					state_d      = S_UPD;
				end else begin
					cmd.v_from_div = 1'b1;
					state_d        = S_MUL1;
				end
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = S_SQS;
			end
			S_SQS: begin
				cmd.sq_start = 1'b1;
				state_d      = S_SQRT;
			end
			S_SQRT: begin
				if (sts.sq_done) begin
					state_d = S_SATC;
				end else begin
					cmd.sq_step = 1'b1;
				end
			end
			S_SATC: begin
				if (sts.sat) begin
					cmd.res_sat = 1'b1;
					state_d     = S_UPD;
				end else begin
					cmd.div2_start = 1'b1;
					state_d        = S_DIV2;
				end
			end
			S_DIV2: begin
				if (sts.div_done) begin
					cmd.res_div = 1'b1;
					state_d     = S_UPD;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				state_d = S_JCHK;
			end
			S_FIN: begin
				if (!result_valid_q || result_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

endmodule

[sv/wssm_dp.sv]
module wssm_dp #(
	parameter int GRID_DEPTH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  wssm_pkg::item_t   item,
	input  logic              wr_en,
	input  logic [2:0]        wr_index,
	input  logic [31:0]       wr_data,
	input  wssm_pkg::cmd_t    cmd,
	output wssm_pkg::sts_t    sts,
	output wssm_pkg::result_t result
);
	import wssm_pkg::*;

	localparam int AW = (GRID_DEPTH > 1) ? $clog2(GRID_DEPTH) : 1;
	localparam int LW = $clog2(GRID_DEPTH + 1);
	localparam int RW = ((LW > 12) ? LW : 12) + 2;

	localparam logic signed [RW-1:0] ONE_S  = 1;
	localparam logic signed [RW-1:0] ZERO_S = 0;

	localparam logic [5:0] DIV1_STEPS = 6'd49;
	localparam logic [5:0] DIV2_STEPS = 6'd31;
	localparam logic [5:0] SQ_STEPS   = 6'd42;

	typedef struct packed {
		logic [31:0] cc;
		logic [31:0] tc;
		logic [31:0] cp;
		logic [31:0] tp;
		logic [31:0] pos;
	} entry_t;

	// configuration
	logic [15:0] case_fraction_q;
	logic [31:0] scale_factor_q;
	logic [31:0] total_count_q;
	logic [10:0] max_window_q;
	logic [1:0]  scan_mode_q;
	logic [10:0] left_center_q;
	logic [10:0] right_center_q;
	logic [LW-1:0] loaded_q;

	logic          row_ok;
	logic [LW-1:0] row_p1;

	assign row_ok = (int'(item.row_index) < GRID_DEPTH);
	assign row_p1 = LW'(item.row_index) + LW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			case_fraction_q <= 16'd32768;
			scale_factor_q  <= 32'd16384;
			total_count_q   <= 32'd1;
			max_window_q    <= 11'd1;
			scan_mode_q     <= 2'd0;
			left_center_q   <= 11'd1;
			right_center_q  <= 11'd1;
			loaded_q        <= '0;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					REG_CASE_FRACTION: case_fraction_q <= wr_data[15:0];
					REG_SCALE_FACTOR:  scale_factor_q  <= wr_data;
					REG_TOTAL_COUNT:   total_count_q   <= wr_data;
					REG_MAX_WINDOW:    max_window_q    <= wr_data[10:0];
					REG_SCAN_MODE:     scan_mode_q     <= wr_data[1:0];
					REG_LEFT_CENTER:   left_center_q   <= wr_data[10:0];
					REG_RIGHT_CENTER:  right_center_q  <= wr_data[10:0];
					default: ;
				endcase
			end
			if (cmd.load_wr && row_ok && (row_p1 > loaded_q)) begin
				loaded_q <= row_p1;
			end
		end
	end

	// grid store
	entry_t        mem [GRID_DEPTH];
	entry_t        rd_q;
	entry_t        wr_entry;
	logic          mem_re;
	logic [AW-1:0] rd_addr;

	logic [9:0]             row_q;
	logic signed [RW-1:0]   j_q, jhi_q, best_j_q;

	assign wr_entry = '{cc: item.case_cum, tc: item.total_cum, cp: item.case_point,
		tp: item.total_point, pos: item.grid_position};
	assign mem_re   = cmd.rd_i | cmd.rd_j | cmd.rd_best;

	always_comb begin
		priority if (cmd.rd_i) begin
			rd_addr = AW'(row_q);
		end else if (cmd.rd_j) begin
			rd_addr = j_q[AW-1:0];
		end else begin
			rd_addr = best_j_q[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_wr && row_ok) begin
			mem[AW'(item.row_index)] <= wr_entry;
		end
		if (mem_re) begin
			rd_q <= mem[rd_addr];
		end
	end

	// window range
	logic signed [RW-1:0] i_s, m_s, h_s, mw_s, gl_s, gr_s;
	logic signed [RW-1:0] ll_s, lr_s, rl_s, rr_s, ip1_s, ipw_s, lmh_s, lph_s, rmh_s, rph_s;
	logic signed [RW-1:0] jlo_c, jhi_c, bj_c;
	logic                 ok_c;

	always_comb begin
		i_s   = $signed(RW'(row_q));
		m_s   = $signed(RW'(loaded_q)) - ONE_S;
		h_s   = $signed(RW'(max_window_q[10:1]));
		mw_s  = $signed(RW'(max_window_q));
		gl_s  = $signed(RW'(left_center_q)) - ONE_S;
		gr_s  = $signed(RW'(right_center_q)) - ONE_S;
		lmh_s = gl_s - h_s;
		lph_s = gl_s + h_s;
		rmh_s = gr_s - h_s;
		rph_s = gr_s + h_s;
		ll_s  = (lmh_s < ZERO_S) ? ZERO_S : lmh_s;
		lr_s  = (lph_s > m_s - ONE_S) ? m_s - ONE_S : lph_s;
		rl_s  = (rmh_s < ZERO_S) ? ZERO_S : rmh_s;
		rr_s  = (rph_s > m_s) ? m_s : rph_s;
		ip1_s = i_s + ONE_S;
		ipw_s = i_s + mw_s;
		if (scan_mode_q[1]) begin
			ok_c  = (i_s >= ll_s) && (i_s <= lr_s);
			jlo_c = (ip1_s > rl_s) ? rl_s : ip1_s;
			jhi_c = rr_s;
			bj_c  = (rr_s < ZERO_S) ? ZERO_S : rr_s;
		end else begin
			ok_c  = (i_s < m_s);
			jlo_c = ip1_s;
			jhi_c = (ipw_s > m_s) ? m_s : ipw_s;
			bj_c  = jhi_c;
		end
	end

	// window arithmetic
	logic [31:0]          pos_i_q;
	logic signed [32:0]   ob_base_q, ca_base_q;
	logic signed [33:0]   obs_q, cases_q;
	logic signed [51:0]   num_q, num_c;
	logic signed [50:0]   pobs_c;
	logic                 ez_q;
	logic [63:0]          sq_q;
	logic [49:0]          v_q, vo_c;
	logic [81:0]          prod_q;
	logic [56:0]          p1_c, p2_c;
	logic [50:0]          mag_c;
	logic [30:0]          res_q, best_mag_q;
	logic                 best_neg_q;

	logic [42:0] dv_rem_q, dv_t_c;
	logic [48:0] dv_sh_q, dv_quo_q;
	logic [41:0] dv_den_q;
	logic [5:0]  dv_cnt_q;
	logic        dv_ge_c;

	logic [83:0] sq_op_q;
	logic [45:0] sq_rem_q, sq_r2_c, sq_tr_c;
	logic [41:0] sq_root_q;
	logic [5:0]  sq_cnt_q;
	logic        sq_ge_c;

	assign pobs_c  = $signed({1'b0, case_fraction_q}) * obs_q;
	assign num_c   = 52'($signed({cases_q, 16'h0000})) - 52'(pobs_c);
	assign mag_c   = num_q[51] ? 51'(-num_q) : 51'(num_q);
	assign vo_c    = 50'({obs_q[32:0], 16'h0000});
	assign p1_c    = scale_factor_q * v_q[24:0];
	assign p2_c    = scale_factor_q * v_q[49:25];
	assign dv_t_c  = {dv_rem_q[41:0], dv_sh_q[48]};
	assign dv_ge_c = (dv_t_c >= {1'b0, dv_den_q});
	assign sq_r2_c = {sq_rem_q[43:0], sq_op_q[83:82]};
	assign sq_tr_c = {2'b00, sq_root_q, 2'b01};
	assign sq_ge_c = (sq_r2_c >= sq_tr_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_cnt_q <= '0;
			sq_cnt_q <= '0;
		end else begin
			if (cmd.div1_start) begin
				dv_cnt_q <= DIV1_STEPS;
			end else if (cmd.div2_start) begin
				dv_cnt_q <= DIV2_STEPS;
			end else if (cmd.div_step) begin
				dv_cnt_q <= dv_cnt_q - 6'd1;
			end
			if (cmd.sq_start) begin
				sq_cnt_q <= SQ_STEPS;
			end else if (cmd.sq_step) begin
				sq_cnt_q <= sq_cnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			row_q <= item.row_index;
		end
		if (cmd.rd_i) begin
			j_q        <= jlo_c;
			jhi_q      <= jhi_c;
			best_j_q   <= bj_c;
			best_mag_q <= '0;
			best_neg_q <= 1'b0;
		end
		if (cmd.cap_i) begin
			pos_i_q   <= rd_q.pos;
			ob_base_q <= $signed({1'b0, rd_q.tp}) - $signed({1'b0, rd_q.tc});
			ca_base_q <= $signed({1'b0, rd_q.cp}) - $signed({1'b0, rd_q.cc});
		end
		if (cmd.cap_obs) begin
			obs_q   <= $signed({2'b00, rd_q.tc}) + 34'(ob_base_q);
			cases_q <= $signed({2'b00, rd_q.cc}) + 34'(ca_base_q);
		end
		if (cmd.eval) begin
			num_q <= num_c;
			ez_q  <= (obs_q <= 34'sd0) || (scan_mode_q[0] && ((total_count_q == 32'd0)
				|| (obs_q > $signed({2'b00, total_count_q}))));
			sq_q  <= obs_q[31:0] * obs_q[31:0];
		end
		if (cmd.div1_start) begin
			dv_rem_q <= 43'(sq_q[63:33]);
			dv_sh_q  <= {sq_q[32:0], 16'h0000};
			dv_den_q <= 42'(total_count_q);
			dv_quo_q <= '0;
		end else if (cmd.div2_start) begin
			dv_rem_q <= 43'(mag_c[50:15]);
			dv_sh_q  <= {mag_c[14:0], 34'h0};
			dv_den_q <= sq_root_q;
			dv_quo_q <= '0;
		end else if (cmd.div_step) begin
			dv_rem_q <= dv_ge_c ? dv_t_c - {1'b0, dv_den_q} : dv_t_c;
			dv_sh_q  <= {dv_sh_q[47:0], 1'b0};
			dv_quo_q <= {dv_quo_q[47:0], dv_ge_c};
		end
		if (cmd.v_from_obs) begin
			v_q <= vo_c;
		end else if (cmd.v_from_div) begin
			v_q <= vo_c - 50'(dv_quo_q);
		end
		if (cmd.mul1) begin
			prod_q <= 82'(p1_c);
		end else if (cmd.mul2) begin
			prod_q <= prod_q + {p2_c, 25'h0};
		end
		if (cmd.sq_start) begin
			sq_op_q   <= {2'b00, prod_q};
			sq_rem_q  <= '0;
			sq_root_q <= '0;
		end else if (cmd.sq_step) begin
			sq_op_q   <= {sq_op_q[81:0], 2'b00};
			sq_rem_q  <= sq_ge_c ? sq_r2_c - sq_tr_c : sq_r2_c;
			sq_root_q <= {sq_root_q[40:0], sq_ge_c};
		end
		priority if (cmd.res_zero) begin
			res_q <= '0;
		end else if (cmd.res_sat) begin
			res_q <= 31'h7FFFFFFF;
		end else if (cmd.res_div) begin
			res_q <= dv_quo_q[30:0];
		end
		if (cmd.upd) begin
			if (res_q > best_mag_q) begin
				best_mag_q <= res_q;
				best_neg_q <= num_q[51];
				best_j_q   <= j_q;
			end
			j_q <= j_q + ONE_S;
		end
		if (cmd.out_load) begin
			result.start_row    <= row_q;
			result.window_start <= pos_i_q;
			result.window_end   <= rd_q.pos;
			result.best_statistic <= best_neg_q ? -$signed({1'b0, best_mag_q})
				: $signed({1'b0, best_mag_q});
		end
	end

	assign sts.range_ok   = ok_c;
	assign sts.j_over     = (j_q > jhi_q);
	assign sts.rabin      = scan_mode_q[0];
	assign sts.early_zero = ez_q || (num_q == 52'sd0);
	assign sts.div_done   = (dv_cnt_q == 6'd0);
	assign sts.v_neg      = (50'(dv_quo_q) >= vo_c);
	assign sts.sq_done    = (sq_cnt_q == 6'd0);
	assign sts.sat        = (sq_root_q == 42'd0) || (57'(mag_c) >= {sq_root_q, 15'h0000});

endmodule

[sv/window_scan_statistic_max.sv]
// Window scan statistic, largest magnitude. A load transfer writes one grid row
// into a single-port store and yields no result. A scan transfer walks the
// window ends of its start row one at a time through a shared datapath: per end
// a store read, the numerator, an optional 49-step divide for the Rabin
// variance, a scale multiply in MUL1 and MUL2, a 42-step square root and a
// 31-step divide. An end rejected before any divide, or with a negative
// variance, skips the rest; a saturated result skips the last divide. A new
// transfer is taken while a result waits in the output register; a scan that
// finishes before that result is taken holds.
module window_scan_statistic_max #(
	parameter int GRID_DEPTH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  wssm_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output wssm_pkg::result_t result,
	input  logic              wr_en,
	input  logic [2:0]        wr_index,
	input  logic [31:0]       wr_data
);
	import wssm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	wssm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item_is_scan (item.opcode == OP_SCAN),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.cmd          (cmd),
		.sts          (sts)
	);

	wssm_dp #(
		.GRID_DEPTH (GRID_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cmd      (cmd),
		.sts      (sts),
		.result   (result)
	);

endmodule
